// ===== rtl/core/pwf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pwf_pkg - shared types and control store for the proportional width fit
// Step codes, jump conditions, the control word layout and the microprogram.
// ----------------------------------------------------------------------------
package pwf_pkg;

    // Field widths
    localparam int DESIRED_W = 16;              // signed desired width
    localparam int FIT_W     = 15;              // clamped / granted width
    localparam int PROD_W    = 2 * FIT_W;       // width times remaining budget
    localparam int DIV_CNT_W = 4;               // counts FIT_W quotient bits

    // Defaults
    localparam int                      MAX_COLUMNS_DEF = 16;
    localparam logic signed [DESIRED_W-1:0] AVAIL_RESET = 16'sd584;

    // Microprogram step addresses
    typedef enum logic [3:0] {
        P_IDLE   = 4'd0,
        P_SETUP  = 4'd1,
        P_DREAD  = 4'd2,
        P_DLOAD  = 4'd3,
        P_DSTART = 4'd4,
        P_DITER  = 4'd5,
        P_DSTORE = 4'd6,
        P_SHORT  = 4'd7,
        P_EREAD  = 4'd8,
        P_EWAIT  = 4'd9,
        P_EOUT   = 4'd10,
        P_ENEXT  = 4'd11,
        P_EDONE  = 4'd12
    } step_t;

    // Jump conditions: jump to target when true, else fall through
    typedef enum logic [2:0] {
        C_NEVER    = 3'd0,
        C_ALWAYS   = 3'd1,
        C_NO_CLOSE = 3'd2,
        C_FITS     = 3'd3,
        C_DIV_BUSY = 3'd4,
        C_MORE     = 3'd5,
        C_OUT_BUSY = 3'd6
    } cond_t;

    typedef struct packed {
        logic  accept;      // take input words
        logic  setup;       // latch budget, base, rest, fit flag
        logic  rd;          // read both stores at the column index
        logic  mul;         // register width times rest
        logic  div_init;    // load divider
        logic  div_step;    // one restoring divide step
        logic  store;       // write granted width, add share to allocation
        logic  short_calc;  // compute shortfall
        logic  out_load;    // load the output word
        logic  col_inc;     // advance column index
        logic  done;        // clear the set
        cond_t cond;
        step_t target;
    } ctrl_word_t;

    localparam ctrl_word_t CW_NOP = '{
        accept: 1'b0, setup: 1'b0, rd: 1'b0, mul: 1'b0, div_init: 1'b0,
        div_step: 1'b0, store: 1'b0, short_calc: 1'b0, out_load: 1'b0,
        col_inc: 1'b0, done: 1'b0, cond: C_NEVER, target: P_IDLE
    };

    // Control store
    function automatic ctrl_word_t ucode(input step_t step);
        ctrl_word_t w;
        w = CW_NOP;
        case (step)
            P_IDLE:   begin w.accept = 1'b1; w.cond = C_NO_CLOSE; w.target = P_IDLE; end
            P_SETUP:  begin w.setup = 1'b1; w.cond = C_FITS; w.target = P_EREAD; end
            P_DREAD:  begin w.rd = 1'b1; end
            P_DLOAD:  begin w.mul = 1'b1; end
            P_DSTART: begin w.div_init = 1'b1; end
            P_DITER:  begin w.div_step = 1'b1; w.cond = C_DIV_BUSY; w.target = P_DITER; end
            P_DSTORE: begin
                w.store = 1'b1; w.col_inc = 1'b1; w.cond = C_MORE; w.target = P_DREAD;
            end
            P_SHORT:  begin w.short_calc = 1'b1; end
            P_EREAD:  begin w.rd = 1'b1; end
            P_EWAIT:  begin w.cond = C_OUT_BUSY; w.target = P_EWAIT; end
            P_EOUT:   begin w.out_load = 1'b1; end
            P_ENEXT:  begin w.col_inc = 1'b1; w.cond = C_MORE; w.target = P_EREAD; end
            P_EDONE:  begin w.done = 1'b1; w.cond = C_ALWAYS; w.target = P_IDLE; end
            default:  begin w.cond = C_ALWAYS; w.target = P_IDLE; end
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/pwf_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pwf_ram - generic single write port RAM with registered read
// One write and one read address per cycle; read data held until next read.
// ----------------------------------------------------------------------------
module pwf_ram #(
    parameter int  WIDTH = 15,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/proportional_width_fit_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// proportional_width_fit_unit - fit a set of column widths into a budget
// Microcoded sequencer over a shared multiplier and restoring divider.
// ----------------------------------------------------------------------------
// Columns arrive one word per cycle while the unit is idle; a word with
// last_column set, or the word that fills MAX_COLUMNS slots, closes the set
// and the input stalls until every fitted width of that set has been handed
// to the output register. Negative widths count as zero and a budget below
// one counts as one. If the set fits, the wanted widths are streamed out
// as they are; otherwise each column costs a store read, a multiply, a
// divider load and 15 one-bit restoring steps, and the shortfall is then
// worked out before the results are streamed out in order. The last result
// word may still wait in the output register while the next set is loaded.
// ----------------------------------------------------------------------------
module proportional_width_fit_unit
    import pwf_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // configuration
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic signed [DESIRED_W-1:0] width_budget,
    // input words
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic signed [DESIRED_W-1:0] desired_width,
    input  wire logic                        last_column,
    // output words
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic             [FIT_W-1:0]     fitted_width,
    output logic                             last_result
);

    localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int NW = AW + 1;
    localparam int TW = FIT_W + $clog2(MAX_COLUMNS);
    localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_COLUMNS - 1);

    // Sequencer and control word
    step_t      step_reg, step_next;
    ctrl_word_t cw;
    logic       jump;

    // Datapath registers
    logic signed [DESIRED_W-1:0] avail_reg, avail_next;
    logic [AW-1:0]     count_reg, count_next;
    logic [AW-1:0]     last_idx_reg, last_idx_next;
    logic [TW-1:0]     total_reg, total_next;
    logic [AW-1:0]     col_reg, col_next;
    logic [FIT_W-1:0]  budget_reg, budget_next;
    logic [FIT_W-1:0]  rest_reg, rest_next;
    logic              base_reg, base_next;
    logic              fits_reg, fits_next;
    logic [FIT_W-1:0]  alloc_reg, alloc_next;
    logic [FIT_W-1:0]  short_reg, short_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [TW-1:0]     rem_reg, rem_next;
    logic [FIT_W-1:0]  quo_reg, quo_next;
    logic [DIV_CNT_W-1:0] dcnt_reg, dcnt_next;
    logic              out_valid_reg, out_valid_next;
    logic [FIT_W-1:0]  fitted_reg, fitted_next;
    logic              last_reg, last_next;

    // Combinational helpers
    logic              accept;
    logic              closing;
    logic [FIT_W-1:0]  clamped;
    logic [FIT_W-1:0]  wanted_rd;
    logic [FIT_W-1:0]  granted_rd;
    logic [FIT_W-1:0]  budget_now;
    logic [NW-1:0]     n_cols;
    logic              base_now;
    logic [TW:0]       trial;
    logic              trial_ge;
    logic              bump;

    assign cw        = ucode(step_reg);
    assign cfg_ready = 1'b1;
    assign in_stall  = !cw.accept;
    assign accept    = in_valid && cw.accept;
    assign closing   = last_column || (count_reg == LAST_SLOT);
    assign clamped   = desired_width[DESIRED_W-1] ? '0 : desired_width[FIT_W-1:0];

    assign out_valid    = out_valid_reg;
    assign fitted_width = fitted_reg;
    assign last_result  = last_reg;

    // Column stores
    pwf_ram #(.WIDTH(FIT_W), .DEPTH(MAX_COLUMNS)) u_wanted_ram (
        .clk   (clk),
        .we    (accept),
        .waddr (count_reg),
        .wdata (clamped),
        .re    (cw.rd),
        .raddr (col_reg),
        .rdata (wanted_rd)
    );

    pwf_ram #(.WIDTH(FIT_W), .DEPTH(MAX_COLUMNS)) u_granted_ram (
        .clk   (clk),
        .we    (cw.store),
        .waddr (col_reg),
        .wdata (quo_reg + FIT_W'(base_reg)),
        .re    (cw.rd),
        .raddr (col_reg),
        .rdata (granted_rd)
    );

    // Jump condition and next step
    always_comb
    begin
        case (cw.cond)
            C_NEVER:    jump = 1'b0;
            C_ALWAYS:   jump = 1'b1;
            C_NO_CLOSE: jump = !(accept && closing);
            C_FITS:     jump = fits_next;
            C_DIV_BUSY: jump = (dcnt_reg != DIV_CNT_W'(1));
            C_MORE:     jump = (col_reg != last_idx_reg);
            C_OUT_BUSY: jump = out_valid_reg && out_stall;
            default:    jump = 1'b1;
        endcase
    end

    always_comb
    begin
        if (jump)
        begin
            step_next = cw.target;
        end
        else
        begin
            step_next = step_t'(step_reg + 4'd1);
        end
    end

    // Budget terms for setup
    assign budget_now = (avail_reg < 1) ? FIT_W'(1) : avail_reg[FIT_W-1:0];
    assign n_cols     = NW'(last_idx_reg) + NW'(1);
    assign base_now   = (budget_now >= FIT_W'(n_cols));

    // One restoring divide step
    assign trial    = {rem_reg, quo_reg[FIT_W-1]};
    assign trial_ge = (trial >= {1'b0, total_reg});

    // Round-robin shortfall: the first columns each take one extra unit
    assign bump = (FIT_W'(col_reg) < short_reg);

    // Datapath next values
    always_comb
    begin
        avail_next     = avail_reg;
        count_next     = count_reg;
        last_idx_next  = last_idx_reg;
        total_next     = total_reg;
        col_next       = col_reg;
        budget_next    = budget_reg;
        rest_next      = rest_reg;
        base_next      = base_reg;
        fits_next      = fits_reg;
        alloc_next     = alloc_reg;
        short_next     = short_reg;
        prod_next      = prod_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        dcnt_next      = dcnt_reg;
        out_valid_next = out_valid_reg;
        fitted_next    = fitted_reg;
        last_next      = last_reg;

        // budget register write
        if (cfg_valid)
        begin
            avail_next = width_budget;
        end

        // collect a column
        if (accept)
        begin
            total_next = total_reg + TW'(clamped);
            if (closing)
            begin
                last_idx_next = count_reg;
            end
            else
            begin
                count_next = count_reg + AW'(1);
            end
        end

        // latch budget terms for the closed set
        if (cw.setup)
        begin
            budget_next = budget_now;
            fits_next   = ({{(TW-FIT_W){1'b0}}, budget_now} >= total_reg);
            base_next   = base_now;
            rest_next   = base_now ? (budget_now - FIT_W'(n_cols)) : budget_now;
            alloc_next  = base_now ? FIT_W'(n_cols) : '0;
            short_next  = '0;
            col_next    = '0;
        end

        // multiply wanted width by the rest of the budget
        if (cw.mul)
        begin
            prod_next = PROD_W'(wanted_rd) * PROD_W'(rest_reg);
        end

        // load the divider: high half as remainder, low half shifted in
        if (cw.div_init)
        begin
            rem_next  = TW'(prod_reg[PROD_W-1:FIT_W]);
            quo_next  = prod_reg[FIT_W-1:0];
            dcnt_next = DIV_CNT_W'(FIT_W);
        end

        if (cw.div_step)
        begin
            rem_next  = trial_ge ? TW'(trial - {1'b0, total_reg}) : trial[TW-1:0];
            quo_next  = {quo_reg[FIT_W-2:0], trial_ge};
            dcnt_next = dcnt_reg - DIV_CNT_W'(1);
        end

        // account the share just written
        if (cw.store)
        begin
            alloc_next = alloc_reg + quo_reg;
        end

        if (cw.short_calc)
        begin
            short_next = budget_reg - alloc_reg;
            col_next   = '0;
        end

        if (cw.col_inc)
        begin
            col_next = col_reg + AW'(1);
        end

        // drop the output word once taken, load a new one
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cw.out_load)
        begin
            out_valid_next = 1'b1;
            fitted_next    = fits_reg ? wanted_rd : (granted_rd + FIT_W'(bump));
            last_next      = (col_reg == last_idx_reg);
        end

        // clear the set
        if (cw.done)
        begin
            count_next = '0;
            total_next = '0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= P_IDLE;
            avail_reg     <= AVAIL_RESET;
            count_reg     <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            dcnt_reg      <= '0;
            col_reg       <= '0;
        end
        else
        begin
            step_reg      <= step_next;
            avail_reg     <= avail_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
            dcnt_reg      <= dcnt_next;
            col_reg       <= col_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        last_idx_reg <= last_idx_next;
        budget_reg   <= budget_next;
        rest_reg     <= rest_next;
        base_reg     <= base_next;
        fits_reg     <= fits_next;
        alloc_reg    <= alloc_next;
        short_reg    <= short_next;
        prod_reg     <= prod_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        fitted_reg   <= fitted_next;
        last_reg     <= last_next;
    end

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - proportional width fit unit
// Drives column sets under changing budgets, predicts every fitted width and
// checks each output word in order, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module testbench;
    import pwf_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 100;
    localparam int SETTLE       = 30;
    localparam int LONG_HOLD    = 400;
    localparam int MAX_REPORTS  = 50;

    typedef struct packed {
        logic [FIT_W-1:0] width;
        logic             last;
    } grant_t;

    // Fitted-width predictor and the queue of grants still owed by the unit
    class column_fit_board;
        logic signed [DESIRED_W-1:0] budget_reg;
        logic [FIT_W-1:0]            wanted [MAX_COLUMNS_DEF];
        int unsigned                 held;
        logic [19:0]                 wanted_sum;
        grant_t                      grant_q[$];
        int                          errors;
        int                          sets;
        int                          squeezed;
        int                          columns;
        int                          results;

        function new();
            budget_reg = AVAIL_RESET;
            held       = 0;
            wanted_sum = '0;
            errors     = 0;
            sets       = 0;
            squeezed   = 0;
            columns    = 0;
            results    = 0;
        endfunction

        function void set_budget(logic signed [DESIRED_W-1:0] v);
            budget_reg = v;
        endfunction

        // Share the budget over the held columns and queue the grants
        function void share_out();
            longint unsigned  cap;
            longint unsigned  base;
            longint unsigned  rest;
            longint unsigned  spent;
            longint unsigned  part;
            logic [FIT_W-1:0] granted [MAX_COLUMNS_DEF];
            grant_t           g;
            int               i;
            cap = (budget_reg < 1) ? 1 : longint'(budget_reg);
            if (wanted_sum <= cap) begin
                for (i = 0; i < held; i++)
                    granted[i] = wanted[i];
            end
            else begin
                squeezed++;
                base  = (cap >= held) ? 1 : 0;
                rest  = cap - base * held;
                spent = base * held;
                for (i = 0; i < held; i++) begin
                    part       = (longint'(wanted[i]) * rest) / longint'(wanted_sum);
                    granted[i] = FIT_W'(base + part);
                    spent      = spent + part;
                end
                // hand out the flooring shortfall round-robin from column 0
                i = 0;
                while (spent < cap) begin
                    granted[i % held] = granted[i % held] + 1'b1;
                    i++;
                    spent++;
                end
            end
            for (i = 0; i < held; i++) begin
                g.width = granted[i];
                g.last  = (i + 1 == held);
                grant_q.push_back(g);
            end
            sets++;
        endfunction

        // Note one accepted column word
        function void note_column(logic signed [DESIRED_W-1:0] w, logic last);
            logic [FIT_W-1:0] clamped;
            clamped      = (w < 0) ? '0 : w[FIT_W-1:0];
            wanted[held] = clamped;
            wanted_sum   = wanted_sum + clamped;
            held++;
            columns++;
            if (last || held == MAX_COLUMNS_DEF) begin
                share_out();
                held       = 0;
                wanted_sum = '0;
            end
        endfunction

        task report(string msg);
            if (errors < MAX_REPORTS)
                $display("MISMATCH @%0t: %s", $time, msg);
            errors++;
        endtask

        // Compare one output word with the oldest grant owed
        task check_grant(logic [FIT_W-1:0] w, logic last);
            grant_t e;
            results++;
            if (grant_q.size() == 0) begin
                report($sformatf("unexpected word width=%0d last=%0b", w, last));
            end
            else begin
                e = grant_q.pop_front();
                if (w !== e.width)
                    report($sformatf("fitted_width %0d, predicted %0d", w, e.width));
                if (last !== e.last)
                    report($sformatf("last_result %0b, predicted %0b", last, e.last));
            end
        endtask
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic signed [DESIRED_W-1:0] width_budget;
    logic                        in_valid;
    logic                        in_stall;
    logic signed [DESIRED_W-1:0] desired_width;
    logic                        last_column;
    logic                        out_valid;
    logic                        out_stall;
    logic [FIT_W-1:0]            fitted_width;
    logic                        last_result;

    column_fit_board board;
    bit              sender_burst;
    bit              receiver_burst;
    bit              hold_request;
    int              cycles;
    int              budget_writes;

    proportional_width_fit_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .width_budget    (width_budget),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .desired_width   (desired_width),
        .last_column     (last_column),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .fitted_width    (fitted_width),
        .last_result     (last_result)
    );

    // Clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Give up after a generous number of cycles
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Watch both channels at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                board.note_column(desired_width, last_column);
            if (out_valid && !out_stall)
                board.check_grant(fitted_width, last_result);
        end
    end

    // Receiver: stall for a drawn number of cycles, then take one word
    initial
    begin
        int k;
        out_stall = 1'b1;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            k = receiver_burst ? 0 : $urandom_range(0, 17);
            if (hold_request)
            begin
                k = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (k > 0)
            begin
                out_stall = 1'b1;
                repeat (k) @(negedge clk);
            end
            out_stall = 1'b0;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    // Offer one column word after a drawn gap and hold it until taken
    task send_column(input logic signed [DESIRED_W-1:0] w, input logic last);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid      = 1'b1;
        desired_width = w;
        last_column   = last;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    // Write the budget register
    task write_budget(input logic signed [DESIRED_W-1:0] v);
        cfg_valid    = 1'b1;
        width_budget = v;
        do @(posedge clk); while (!cfg_ready);
        board.set_budget(v);
        budget_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Hold the sender until every owed grant has arrived, then let the unit settle
    task drain();
        in_valid = 1'b0;
        while (board.grant_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic signed [DESIRED_W-1:0] pick_width();
        case ($urandom_range(0, 9))
            0, 1:       return DESIRED_W'($urandom);
            2, 3, 4, 5: return DESIRED_W'($urandom_range(0, 600));
            6, 7:       return DESIRED_W'($urandom_range(0, 32767));
            8:          return DESIRED_W'(-$urandom_range(1, 32768));
            default:    return $urandom_range(0, 1) ? 16'sd32767 : 16'sd0;
        endcase
    endfunction

    function automatic logic signed [DESIRED_W-1:0] pick_budget();
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sd32767;
            2:       return 16'sd0;
            3:       return 16'sd1;
            4:       return DESIRED_W'($urandom_range(1, 200));
            5:       return DESIRED_W'($urandom_range(200, 5000));
            6:       return DESIRED_W'($urandom);
            default: return DESIRED_W'($urandom_range(5000, 32767));
        endcase
    endfunction

    // One random set: mostly short, sometimes long, now and then overrunning
    task random_set(output int n);
        int  i;
        logic closes;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: n = $urandom_range(1, 5);
            7, 8:                n = $urandom_range(6, 15);
            default:             n = MAX_COLUMNS_DEF;
        endcase
        closes = (n < MAX_COLUMNS_DEF) ? 1'b1 : 1'($urandom_range(0, 1));
        for (i = 0; i < n; i++)
            send_column(pick_width(), (i == n - 1) ? closes : 1'b0);
    endtask

    initial
    begin
        int i;
        int n;
        int phase;
        int sent;
        int sets_in_phase;
        board           = new();
        cycles          = 0;
        budget_writes   = 0;
        sender_burst    = 1'b0;
        receiver_burst  = 1'b0;
        hold_request    = 1'b0;
        cfg_valid       = 1'b0;
        width_budget    = AVAIL_RESET;
        in_valid        = 1'b0;
        desired_width   = '0;
        last_column     = 1'b0;
        rst_n           = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset budget: widest column alone, then negatives clamped to zero
        send_column(16'sd32767, 1'b1);
        send_column(16'sh8000, 1'b0);
        send_column(-16'sd1, 1'b0);
        send_column(16'sd100, 1'b1);
        // overrun: sixteen columns with no closing flag
        for (i = 0; i < MAX_COLUMNS_DEF; i++)
            send_column((i % 4 == 0) ? 16'sd32767 : DESIRED_W'(i * 37), 1'b0);
        drain();

        // Zero budget counts as one: fewer units than columns, no base
        write_budget(16'sd0);
        send_column(16'sd5, 1'b0);
        send_column(16'sd7, 1'b0);
        send_column(16'sd9, 1'b1);
        drain();

        // Most negative budget, shortfall lands on column 0
        write_budget(16'sh8000);
        send_column(16'sd3, 1'b0);
        send_column(16'sd3, 1'b1);
        drain();

        // Largest budget against two widest columns
        write_budget(16'sd32767);
        send_column(16'sd32767, 1'b0);
        send_column(16'sd32767, 1'b1);
        drain();

        // Random phases, each under a fresh budget
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            write_budget(pick_budget());
            sender_burst   = ($urandom_range(0, 3) == 0);
            receiver_burst = ($urandom_range(0, 3) == 0);
            // one phase holds the output off while the sender keeps offering
            if (phase == 2)
            begin
                sender_burst = 1'b1;
                hold_request = 1'b1;
            end
            sets_in_phase = $urandom_range(1, 4);
            for (i = 0; i < sets_in_phase; i++)
            begin
                random_set(n);
                sent += n;
            end
            drain();
            phase++;
        end

        $display("Run covered %0d column sets (%0d squeezed) under %0d budget writes",
                 board.sets, board.squeezed, budget_writes);
        $display("%0d columns offered, %0d fitted widths checked",
                 board.columns, board.results);
        if (board.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/pwf_pkg.sv
rtl/core/pwf_ram.sv
rtl/core/proportional_width_fit_unit.sv
tb/sv/testbench.sv
